// ----- design/rlf_pkg.sv -----
package rlf_pkg;

  // Routing table size and number of outgoing interfaces.
  localparam int unsigned TableEntries = 16;
  localparam int unsigned NumPorts     = 4;

  // Width of a cell index. It is never narrower than the request's slot index field.
  localparam int unsigned IdxW = ($clog2(TableEntries) > 4) ? $clog2(TableEntries) : 4;

  // Request kinds, carried in tuser.
  localparam logic OpWrite = 1'b0;
  localparam logic OpRoute = 1'b1;

  // Result actions.
  localparam logic [2:0] ActForward = 3'd0;
  localparam logic [2:0] ActEcho    = 3'd1;
  localparam logic [2:0] ActUnreach = 3'd2;
  localparam logic [2:0] ActTimeEx  = 3'd3;
  localparam logic [2:0] ActWritten = 3'd4;

  // A request as it moves along the row of table cells. A write carries the
  // entry destination in addr; a route carries the packet destination there.
  // The best_* fields hold the best match found so far.
  typedef struct packed {
    logic        op;
    logic [3:0]  index;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  port;
    logic        entry_valid;
    logic [7:0]  ttl;
    logic [15:0] checksum;
    logic        echo;
    logic        hit;
    logic [31:0] best_mask;
    logic [31:0] best_gateway;
    logic [1:0]  best_port;
  } token_t;

endpackage

// ----- design/rlf_cell.sv -----
// One routing table slot. A request passes through one register: a write
// aimed at this slot stores the entry, and a route compares against the
// stored entry and keeps the better of the two matches.
module rlf_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [rlf_pkg::IdxW-1:0]   cell_idx_i,
  input  logic                       vld_i,
  input  rlf_pkg::token_t            tok_i,
  output logic                       vld_o,
  output rlf_pkg::token_t            tok_o
);

  logic            ent_valid_q;
  logic [31:0]     ent_dest_q;
  logic [31:0]     ent_mask_q;
  logic [31:0]     ent_gateway_q;
  logic [1:0]      ent_port_q;

  logic            vld_q;
  rlf_pkg::token_t tok_q;
  rlf_pkg::token_t tok_d;

  logic            port_ok;
  logic            wr_hit;
  logic            match;
  logic            take;

  assign port_ok = (32'(tok_i.port) < 32'(rlf_pkg::NumPorts));
  assign wr_hit  = vld_i && (tok_i.op == rlf_pkg::OpWrite) && port_ok &&
                   (rlf_pkg::IdxW'(tok_i.index) == cell_idx_i);

  assign match = ent_valid_q && ((tok_i.addr & ent_mask_q) == (ent_dest_q & ent_mask_q));
  // A longer mask wins; on equal masks the earlier slot, already held, stays.
  assign take  = match && (!tok_i.hit || (ent_mask_q > tok_i.best_mask));

  always_comb begin
    tok_d = tok_i;
    if ((tok_i.op == rlf_pkg::OpRoute) && take) begin
      tok_d.hit          = 1'b1;
      tok_d.best_mask    = ent_mask_q;
      tok_d.best_gateway = ent_gateway_q;
      tok_d.best_port    = ent_port_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      vld_q       <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
      if (wr_hit) begin
        ent_valid_q <= tok_i.entry_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
      if (wr_hit) begin
        ent_dest_q    <= tok_i.addr;
        ent_mask_q    <= tok_i.mask;
        ent_gateway_q <= tok_i.gateway;
        ent_port_q    <= tok_i.port;
      end
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

// ----- design/ipv4_route_lookup_forward_core.sv -----
// Channel   Direction  Signals                      Contents
// s_axis    in         tvalid/tready/tdata/tuser    table write or packet route request
// m_axis    out        tvalid/tready/tdata/tuser    action and forwarding decision
//
// Every request flows through the row of table cells and then into the
// output register, and a new request is taken in every cycle while m_axis
// is not stalled.
// Reset clears all table valid bits and all pipeline valid bits.
// A stall on m_axis freezes the whole row at once, so s_axis_tready_o drops
// in the same cycle the output register is full and not taken.
module ipv4_route_lookup_forward_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [3:0] entry_index, [35:4] entry_dest, [67:36] entry_mask,
  // [99:68] entry_gateway, [101:100] entry_port, [102] entry_valid,
  // [134:103] packet_dst, [142:135] packet_ttl, [158:143] packet_checksum,
  // [190:159] rx_iface_addr, [191] zero fill
  input  logic [191:0] s_axis_tdata_i,
  // [0] operation
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] hop_addr, [33:32] out_port, [41:34] new_ttl,
  // [57:42] new_checksum, [63:58] zero fill
  output logic [63:0]  m_axis_tdata_o,
  // [2:0] action
  output logic [2:0]   m_axis_tuser_o
);

  localparam int unsigned N = rlf_pkg::TableEntries;

  logic            advance;
  logic            vld   [0:N];
  rlf_pkg::token_t tok   [0:N];
  rlf_pkg::token_t in_tok;

  // The whole pipeline moves whenever the output register can take a result.
  assign advance         = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = advance;

  // Build the request token. The echo check is made here, so the receiving
  // interface address need not travel down the row.
  always_comb begin
    in_tok              = '0;
    in_tok.op           = s_axis_tuser_i[0];
    in_tok.index        = s_axis_tdata_i[3:0];
    in_tok.mask         = s_axis_tdata_i[67:36];
    in_tok.gateway      = s_axis_tdata_i[99:68];
    in_tok.port         = s_axis_tdata_i[101:100];
    in_tok.entry_valid  = s_axis_tdata_i[102];
    in_tok.ttl          = s_axis_tdata_i[142:135];
    in_tok.checksum     = s_axis_tdata_i[158:143];
    in_tok.echo         = (s_axis_tdata_i[134:103] == s_axis_tdata_i[190:159]);
    if (s_axis_tuser_i[0] == rlf_pkg::OpWrite) begin
      in_tok.addr = s_axis_tdata_i[35:4];
    end else begin
      in_tok.addr = s_axis_tdata_i[134:103];
    end
  end
  assign tok[0] = in_tok;
  assign vld[0] = s_axis_tvalid_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    rlf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (advance),
      .cell_idx_i (rlf_pkg::IdxW'(g)),
      .vld_i      (vld[g]),
      .tok_i      (tok[g]),
      .vld_o      (vld[g+1]),
      .tok_o      (tok[g+1])
    );
  end

  // Final decision on the token leaving the last cell. Checks go in the
  // order write, echo, miss, then TTL; only a forward carries nonzero fields.
  rlf_pkg::token_t tail;
  logic [2:0]      action;
  logic [31:0]     hop_addr;
  logic [1:0]      out_port;
  logic [7:0]      new_ttl;
  logic [15:0]     new_checksum;
  logic [16:0]     cs_sum;
  logic [16:0]     cs_fold1;
  logic [15:0]     cs_fold2;

  assign tail = tok[N];

  // Incremental checksum update for a TTL decrement: ~(~HC + 0xFEFF) with
  // end-around carry folded twice.
  assign cs_sum   = {1'b0, ~tail.checksum} + 17'h0FEFF;
  assign cs_fold1 = {1'b0, cs_sum[15:0]} + 17'(cs_sum[16]);
  assign cs_fold2 = cs_fold1[15:0] + 16'(cs_fold1[16]);

  always_comb begin
    action       = rlf_pkg::ActForward;
    hop_addr     = '0;
    out_port     = '0;
    new_ttl      = '0;
    new_checksum = '0;
    if (tail.op == rlf_pkg::OpWrite) begin
      action = rlf_pkg::ActWritten;
    end else if (tail.echo) begin
      action = rlf_pkg::ActEcho;
    end else if (!tail.hit) begin
      action = rlf_pkg::ActUnreach;
    end else if (tail.ttl <= 8'd1) begin
      action = rlf_pkg::ActTimeEx;
    end else begin
      action       = rlf_pkg::ActForward;
      hop_addr     = (tail.best_gateway != 32'd0) ? tail.best_gateway : tail.addr;
      out_port     = tail.best_port;
      new_ttl      = tail.ttl - 8'd1;
      new_checksum = ~cs_fold2;
    end
  end

  logic        m_valid_q;
  logic [63:0] m_data_q;
  logic [2:0]  m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_data_q <= {6'd0, new_checksum, new_ttl, out_port, hop_addr};
      m_user_q <= action;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // A forwarded packet never leaves with a wrapped or zero TTL.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == rlf_pkg::ActForward)) |->
      (m_axis_tdata_o[41:34] != 8'd0))
    else $error("forwarded result with zero TTL");

  // Every result other than a forward carries all-zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != rlf_pkg::ActForward)) |->
      (m_axis_tdata_o == 64'd0))
    else $error("non-forward result with nonzero fields");

  // A result appears only when a request has left the last table cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(vld[N]))
    else $error("result without a request at the end of the row");

  // While the output is stalled, the request at the end of the row holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> ($stable(vld[N]) && $stable(tail)))
    else $error("row moved during an output stall");

endmodule
